// ----- rtl/core/tri_rast_pkg.sv -----
// Shared types and constants for the triangle edge rasterizer.
// Field widths, command codes and configuration register indexes.
// No dependencies.
package tri_rast_pkg;

  // Fixed field widths of the command and result channels
  localparam int CMD_W   = 2;
  localparam int COORD_W = 16;
  localparam int FILL_W  = 8;
  localparam int PIX_W   = 7;
  localparam int CNT_W   = 15;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Command codes
  localparam cmd_t CMD_DRAW  = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_WRITE = 2'd2;

  // Configuration register indexes
  localparam cfg_idx_t REG_FRAME_WIDTH  = 1'd0;
  localparam cfg_idx_t REG_FRAME_HEIGHT = 1'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 8'd128;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 8'd128;

endpackage

// ----- rtl/core/triangle_edge_rasterizer_unit.sv -----
// Triangle edge rasterizer: top level. Uses tri_rast_pkg and tri_rast_ram.
// Draw: box, clip and setup steps, then a walk over the clipped bounding box,
// one pixel per cycle (covered ones are written through the pixel store port).
// An empty box skips setup and walk. One command is in work at a time.
// After reset the pixel store is zeroed, one entry per cycle, over all
// MAX_WIDTH*MAX_HEIGHT entries; commands wait, configuration writes are taken.
module triangle_edge_rasterizer_unit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int FRAC_BITS  = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // command channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [tri_rast_pkg::CMD_W-1:0]         in_command,
  input  logic signed [tri_rast_pkg::COORD_W-1:0] in_ax,
  input  logic signed [tri_rast_pkg::COORD_W-1:0] in_ay,
  input  logic signed [tri_rast_pkg::COORD_W-1:0] in_bx,
  input  logic signed [tri_rast_pkg::COORD_W-1:0] in_by_coord,
  input  logic signed [tri_rast_pkg::COORD_W-1:0] in_cx,
  input  logic signed [tri_rast_pkg::COORD_W-1:0] in_cy,
  input  logic [tri_rast_pkg::FILL_W-1:0]        in_fill_value,
  input  logic [tri_rast_pkg::PIX_W-1:0]         in_pixel_x,
  input  logic [tri_rast_pkg::PIX_W-1:0]         in_pixel_y,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [tri_rast_pkg::FILL_W-1:0]        out_read_data,
  output logic [tri_rast_pkg::CNT_W-1:0]         out_covered_count,
  // configuration port
  input  logic                                   cfg_write_en,
  input  logic [tri_rast_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tri_rast_pkg::CFG_W-1:0]         cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW    = (XW > YW) ? XW : YW;
  // pixel center at doubled scale, signed
  localparam int PCW   = CW + FRAC_BITS + 2;
  // operand of the setup multiply: center minus doubled vertex
  localparam int DW    = ((PCW > 17) ? PCW : 17) + 1;
  // doubled vertex delta
  localparam int DXW   = 18;
  localparam int EW    = DXW + DW;
  localparam int EVW   = EW + 1;
  localparam int BW    = 18;
  localparam int RBW   = XW + YW;
  localparam int PAW   = tri_rast_pkg::PIX_W + XW;
  localparam int SH    = FRAC_BITS + 1;
  localparam int FW    = tri_rast_pkg::FILL_W;
  localparam int NW    = tri_rast_pkg::CNT_W;

  // state codes
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_BOX   = 4'd2;
  localparam logic [3:0] ST_CLIP  = 4'd3;
  localparam logic [3:0] ST_SETUP = 4'd4;
  localparam logic [3:0] ST_WALK  = 4'd5;
  localparam logic [3:0] ST_RD    = 4'd6;
  localparam logic [3:0] ST_RDW   = 4'd7;
  localparam logic [3:0] ST_WR    = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  // control registers
  logic [3:0]                        state_r, state_nxt;
  logic [2:0]                        step_r;
  logic [AW-1:0]                     clr_addr_r;
  logic [tri_rast_pkg::CFG_W-1:0]    cfg_width_r, cfg_height_r;
  logic                              out_valid_r;

  // command payload
  logic [tri_rast_pkg::CMD_W-1:0]    cmd_r;
  logic signed [tri_rast_pkg::COORD_W-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic [FW-1:0]                     fill_r;
  logic [tri_rast_pkg::PIX_W-1:0]    pix_x_r, pix_y_r;

  // box and setup datapath
  logic signed [tri_rast_pkg::COORD_W-1:0] min_x_r, min_y_r, max_x_r, max_y_r;
  logic signed [DXW-1:0]             dx_r [3];
  logic signed [DXW-1:0]             dy_r [3];
  logic [XW-1:0]                     x0_r, x1_r, x_r;
  logic [YW-1:0]                     y0_r, y1_r, y_r;
  logic signed [EW-1:0]              prod_r;
  logic signed [EVW-1:0]             e_row_r [3];
  logic signed [EVW-1:0]             e_cur_r [3];
  logic [AW-1:0]                     row_base_r;

  // results
  logic [FW-1:0]                     res_rd_r;
  logic [NW-1:0]                     res_cnt_r;
  logic [FW-1:0]                     out_rd_r;
  logic [NW-1:0]                     out_cnt_r;

  // pixel store port
  logic                              ram_we;
  logic [AW-1:0]                     ram_addr;
  logic [FW-1:0]                     ram_wdata;
  logic [FW-1:0]                     ram_rdata;

  logic [XW-1:0] eff_w;
  logic [YW-1:0] eff_h;
  logic          in_xfer;
  logic          out_load;
  logic          in_frame;
  logic [PAW-1:0] pix_addr;

  // Active frame size, saturated at the store dimensions
  always_comb begin
    eff_w = (int'(cfg_width_r) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(cfg_width_r);
    eff_h = (int'(cfg_height_r) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(cfg_height_r);
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Single-pixel access address and frame check
  assign in_frame = (int'(pix_x_r) < int'(eff_w)) && (int'(pix_y_r) < int'(eff_h));
  assign pix_addr = PAW'(PAW'(pix_y_r) * PAW'(eff_w)) + PAW'(pix_x_r);

  // ---------------- bounding box ----------------
  logic signed [tri_rast_pkg::COORD_W-1:0] mnx, mny, mxx, mxy;
  logic signed [16:0] dxs [3];
  logic signed [16:0] dys [3];

  always_comb begin
    mnx = (ax_r < bx_r) ? ax_r : bx_r;
    mnx = (mnx < cx_r) ? mnx : cx_r;
    mny = (ay_r < by_r) ? ay_r : by_r;
    mny = (mny < cy_r) ? mny : cy_r;
    mxx = (ax_r > bx_r) ? ax_r : bx_r;
    mxx = (mxx > cx_r) ? mxx : cx_r;
    mxy = (ay_r > by_r) ? ay_r : by_r;
    mxy = (mxy > cy_r) ? mxy : cy_r;
    // edge 0: B to C, edge 1: C to A, edge 2: A to B
    dxs[0] = 17'(cx_r) - 17'(bx_r);
    dys[0] = 17'(cy_r) - 17'(by_r);
    dxs[1] = 17'(ax_r) - 17'(cx_r);
    dys[1] = 17'(ay_r) - 17'(cy_r);
    dxs[2] = 17'(bx_r) - 17'(ax_r);
    dys[2] = 17'(by_r) - 17'(ay_r);
  end

  // ---------------- floor/ceil and clip ----------------
  logic signed [BW-1:0] rnd, fx0, fy0, fx1, fy1, cx0, cy0, cx1, cy1, w_s, h_s;
  logic                 box_empty;

  always_comb begin
    rnd = BW'((1 << FRAC_BITS) - 1);
    w_s = signed'(BW'(eff_w));
    h_s = signed'(BW'(eff_h));
    fx0 = BW'(min_x_r) >>> FRAC_BITS;
    fy0 = BW'(min_y_r) >>> FRAC_BITS;
    fx1 = (BW'(max_x_r) + rnd) >>> FRAC_BITS;
    fy1 = (BW'(max_y_r) + rnd) >>> FRAC_BITS;
    cx0 = (fx0 < 0) ? '0 : fx0;
    cy0 = (fy0 < 0) ? '0 : fy0;
    cx1 = (fx1 > w_s) ? w_s : fx1;
    cy1 = (fy1 > h_s) ? h_s : fy1;
    box_empty = (cx0 >= cx1) || (cy0 >= cy1);
  end

  // ---------------- setup multiply operands ----------------
  logic signed [16:0]   u2x [3];
  logic signed [16:0]   u2y [3];
  logic [DW-1:0]        px0_u, py0_u;
  logic signed [DW-1:0] px0_s, py0_s;
  logic signed [DXW-1:0] op_a;
  logic signed [DW-1:0]  op_b;
  logic signed [EW-1:0]  prod_nxt;
  logic [2:0]            term;
  logic [1:0]            term_e;

  always_comb begin
    // doubled start vertex of each edge
    u2x[0] = {bx_r, 1'b0};
    u2y[0] = {by_r, 1'b0};
    u2x[1] = {cx_r, 1'b0};
    u2y[1] = {cy_r, 1'b0};
    u2x[2] = {ax_r, 1'b0};
    u2y[2] = {ay_r, 1'b0};
    // first pixel center at doubled scale
    px0_u = DW'({x0_r, 1'b1}) << FRAC_BITS;
    py0_u = DW'({y0_r, 1'b1}) << FRAC_BITS;
    px0_s = signed'(px0_u);
    py0_s = signed'(py0_u);
    // even step: dX * (py - uy), odd step: dY * (px - ux)
    case (step_r)
      3'd0: begin op_a = dx_r[0]; op_b = py0_s - DW'(u2y[0]); end
      3'd1: begin op_a = dy_r[0]; op_b = px0_s - DW'(u2x[0]); end
      3'd2: begin op_a = dx_r[1]; op_b = py0_s - DW'(u2y[1]); end
      3'd3: begin op_a = dy_r[1]; op_b = px0_s - DW'(u2x[1]); end
      3'd4: begin op_a = dx_r[2]; op_b = py0_s - DW'(u2y[2]); end
      3'd5: begin op_a = dy_r[2]; op_b = px0_s - DW'(u2x[2]); end
      default: begin op_a = '0; op_b = '0; end
    endcase
    prod_nxt = EW'(op_a) * EW'(op_b);
    // term whose product sits in prod_r
    term   = step_r - 3'd1;
    term_e = term[2:1];
  end

  // ---------------- walk ----------------
  logic                 cov_pos, cov_neg, covered;
  logic                 last_x, last_y;
  logic signed [EVW-1:0] sx [3];
  logic signed [EVW-1:0] sy [3];

  always_comb begin
    cov_pos = 1'b1;
    cov_neg = 1'b1;
    for (int i = 0; i < 3; i++) begin
      cov_pos = cov_pos && !e_cur_r[i][EVW-1];
      cov_neg = cov_neg && (e_cur_r[i][EVW-1] || (e_cur_r[i] == '0));
      // one pixel step is 2^(FRAC_BITS+1) at doubled scale
      sx[i] = EVW'(dy_r[i]) <<< SH;
      sy[i] = EVW'(dx_r[i]) <<< SH;
    end
    covered = cov_pos || cov_neg;
    last_x  = ((x_r + XW'(1)) == x1_r);
    last_y  = ((y_r + YW'(1)) == y1_r);
  end

  // ---------------- pixel store port ----------------
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(pix_addr);
    ram_wdata = fill_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_r;
        ram_wdata = '0;
      end
      ST_WALK: begin
        ram_we   = covered;
        ram_addr = row_base_r + AW'(x_r);
      end
      ST_WR: begin
        ram_we = in_frame;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tri_rast_ram #(
    .WIDTH (FW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_command)
            tri_rast_pkg::CMD_DRAW:  state_nxt = ST_BOX;
            tri_rast_pkg::CMD_READ:  state_nxt = ST_RD;
            tri_rast_pkg::CMD_WRITE: state_nxt = ST_WR;
            default:                 state_nxt = ST_DONE;
          endcase
        end
      end
      ST_BOX:   state_nxt = ST_CLIP;
      ST_CLIP:  state_nxt = box_empty ? ST_DONE : ST_SETUP;
      ST_SETUP: begin
        if (step_r == 3'd7) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (last_x && last_y) state_nxt = ST_DONE;
      end
      ST_RD:    state_nxt = ST_RDW;
      ST_RDW:   state_nxt = ST_DONE;
      ST_WR:    state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      step_r       <= '0;
      clr_addr_r   <= '0;
      cfg_width_r  <= tri_rast_pkg::FRAME_WIDTH_RST;
      cfg_height_r <= tri_rast_pkg::FRAME_HEIGHT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == ST_SETUP) begin
        step_r <= step_r + 3'd1;
      end else begin
        step_r <= '0;
      end
      if (cfg_write_en) begin
        case (cfg_index)
          tri_rast_pkg::REG_FRAME_WIDTH:  cfg_width_r  <= cfg_data;
          tri_rast_pkg::REG_FRAME_HEIGHT: cfg_height_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    // capture the command on transfer
    if (in_xfer) begin
      cmd_r     <= in_command;
      ax_r      <= in_ax;
      ay_r      <= in_ay;
      bx_r      <= in_bx;
      by_r      <= in_by_coord;
      cx_r      <= in_cx;
      cy_r      <= in_cy;
      fill_r    <= in_fill_value;
      pix_x_r   <= in_pixel_x;
      pix_y_r   <= in_pixel_y;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end

    // vertex extents and doubled edge deltas
    if (state_r == ST_BOX) begin
      min_x_r <= mnx;
      min_y_r <= mny;
      max_x_r <= mxx;
      max_y_r <= mxy;
      for (int i = 0; i < 3; i++) begin
        dx_r[i] <= {dxs[i], 1'b0};
        dy_r[i] <= {dys[i], 1'b0};
      end
    end

    // clipped box, bounds fit once the box is known non-empty
    if (state_r == ST_CLIP) begin
      x0_r <= XW'(cx0);
      x1_r <= XW'(cx1);
      y0_r <= YW'(cy0);
      y1_r <= YW'(cy1);
    end

    // edge values at the first pixel center, one product per cycle
    if (state_r == ST_SETUP) begin
      prod_r <= prod_nxt;
      if (step_r == 3'd0) begin
        row_base_r <= AW'(RBW'(y0_r) * RBW'(eff_w));
      end
      if ((step_r != 3'd0) && (step_r != 3'd7)) begin
        if (!term[0]) begin
          e_row_r[term_e] <= EVW'(prod_r);
        end else begin
          e_row_r[term_e] <= e_row_r[term_e] - EVW'(prod_r);
        end
      end
      if (step_r == 3'd7) begin
        for (int i = 0; i < 3; i++) begin
          e_cur_r[i] <= e_row_r[i];
        end
        x_r <= x0_r;
        y_r <= y0_r;
      end
    end

    // raster walk, one box pixel per cycle
    if (state_r == ST_WALK) begin
      res_cnt_r <= res_cnt_r + NW'(covered);
      if (last_x) begin
        x_r        <= x0_r;
        y_r        <= y_r + YW'(1);
        row_base_r <= row_base_r + AW'(eff_w);
        for (int i = 0; i < 3; i++) begin
          e_row_r[i] <= e_row_r[i] + sy[i];
          e_cur_r[i] <= e_row_r[i] + sy[i];
        end
      end else begin
        x_r <= x_r + XW'(1);
        for (int i = 0; i < 3; i++) begin
          e_cur_r[i] <= e_cur_r[i] - sx[i];
        end
      end
    end

    // read data comes from the registered RAM output, addressed in ST_RD
    if (state_r == ST_RDW) begin
      res_rd_r <= (in_frame && (cmd_r == tri_rast_pkg::CMD_READ)) ? ram_rdata : '0;
    end

    // result register
    if (out_load) begin
      out_rd_r  <= res_rd_r;
      out_cnt_r <= res_cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_covered_count = out_cnt_r;

endmodule

// ----- rtl/core/tri_rast_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module tri_rast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
